// File: design/rmbc_pkg.sv
`timescale 1ns / 1ps

package rmbc_pkg;

  localparam int SizeWidth = 24;
  localparam int SumWidth  = 16;
  localparam int ByteWidth = 8;
  localparam int IdxWidth  = $clog2(SizeWidth);

  // Highest bit of the image size that may set the length of the first part.
  localparam int TopMirrorBit = 23;

  typedef logic [SizeWidth-1:0] size_t;
  typedef logic [SumWidth-1:0]  sum_t;
  typedef logic [ByteWidth-1:0] byte_t;
  typedef logic [IdxWidth-1:0]  idx_t;

  localparam size_t ResetRomSize = size_t'(1);
  localparam sum_t  ComplementMask = 16'hFFFF;

  // Size bits that are allowed to define the first part.
  localparam size_t MirrorMask = (TopMirrorBit >= SizeWidth - 1) ? '1 :
      size_t'((64'd1 << (TopMirrorBit + 1)) - 64'd1);

endpackage

// File: design/rmbc_byte_if.sv
`timescale 1ns / 1ps

interface rmbc_byte_if;
  import rmbc_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rom_byte;

  modport source (output valid, output rom_byte, input ready);
  modport sink (input valid, input rom_byte, output ready);
endinterface

// File: design/rmbc_sum_if.sv
`timescale 1ns / 1ps

interface rmbc_sum_if;
  import rmbc_pkg::*;

  logic valid;
  logic ready;
  sum_t checksum;
  sum_t complement;

  modport source (output valid, output checksum, output complement, input ready);
  modport sink (input valid, input checksum, input complement, output ready);
endinterface

// File: design/rom_mirrored_byte_checksum_top.sv
`timescale 1ns / 1ps

// Mirrored byte checksum of a ROM image. Bytes enter one per cycle on byte_i
// in address order while byte_i.ready is high; after rom_size bytes one item
// with the 16-bit checksum and its complement leaves on sum_o, and the next
// byte starts a new image. Each byte passes an input register and one add
// between that register and the running sums; the last byte also shifts and
// adds the second-part sum on its way into the output register, so the
// sustained rate is one byte per cycle unless a result waits on sum_o.ready.
// Writing rom_size clears the image state and holds byte_i.ready low while
// the part lengths and the doubling shift are derived from it.
module rom_mirrored_byte_checksum_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  rmbc_pkg::size_t  cfg_data_i,
  rmbc_byte_if.sink        byte_i,
  rmbc_sum_if.source       sum_o
);
  import rmbc_pkg::*;

  localparam logic [1:0] SettleCycles = 2'd3;

  function automatic idx_t msb_index(size_t v);
    idx_t idx;
    idx = '0;
    for (int i = 0; i < SizeWidth; i++) begin
      if (v[i]) idx = idx_t'(i);
    end
    return idx;
  endfunction

  // Configuration and lengths derived from it.
  size_t      rom_size_q;
  logic [1:0] settle_q;
  idx_t       p_idx_q;
  size_t      p_len_q;
  logic       has_p_q;
  size_t      rest_len_q;
  idx_t       shift_q;
  logic       rest_zero_q;

  // Image state.
  size_t count_q;
  sum_t  first_q;
  sum_t  rest_q;

  logic  in_valid_q;
  byte_t byte_q;

  logic out_valid_q;
  sum_t checksum_q;
  sum_t complement_q;

  size_t masked_size;
  idx_t  p_idx_d;
  idx_t  rest_idx;
  idx_t  shift_d;
  size_t count_next;
  logic  is_last;
  logic  in_first;
  sum_t  first_new;
  sum_t  rest_new;
  sum_t  part2;
  sum_t  sum_d;
  logic  advance;
  logic  byte_accept;

  assign masked_size = rom_size_q & MirrorMask;
  assign p_idx_d     = msb_index(masked_size);
  assign rest_idx    = msb_index(rest_len_q);
  // Doubling the rest until it reaches the first part's length is a shift by
  // the distance between the two leading bits.
  assign shift_d     = (p_idx_q > rest_idx) ? idx_t'(p_idx_q - rest_idx) : '0;

  assign count_next = count_q + size_t'(1);
  assign is_last    = (count_next == rom_size_q);
  assign in_first   = (count_q < p_len_q);
  assign first_new  = in_first ? sum_t'(first_q + sum_t'(byte_q)) : first_q;
  assign rest_new   = in_first ? rest_q : sum_t'(rest_q + sum_t'(byte_q));
  assign part2      = rest_zero_q ? '0 : sum_t'(rest_new << shift_q);
  assign sum_d      = has_p_q ? sum_t'(first_new + part2) : '0;

  assign advance     = in_valid_q && (!is_last || !out_valid_q || sum_o.ready);
  assign byte_i.ready = (settle_q == 2'd0) && (!in_valid_q || advance);
  assign byte_accept = byte_i.valid && byte_i.ready;

  assign sum_o.valid      = out_valid_q;
  assign sum_o.checksum   = checksum_q;
  assign sum_o.complement = complement_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_size_q  <= ResetRomSize;
      settle_q    <= 2'd0;
      p_idx_q     <= '0;
      p_len_q     <= size_t'(1);
      has_p_q     <= 1'b1;
      rest_len_q  <= '0;
      shift_q     <= '0;
      rest_zero_q <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        rom_size_q <= cfg_data_i;
        settle_q   <= SettleCycles;
      end else if (settle_q != 2'd0) begin
        settle_q <= settle_q - 2'd1;
      end
      p_idx_q     <= p_idx_d;
      has_p_q     <= (masked_size != '0);
      p_len_q     <= (masked_size != '0) ? (size_t'(1) << p_idx_d) : '0;
      rest_len_q  <= rom_size_q - p_len_q;
      shift_q     <= shift_d;
      rest_zero_q <= (rest_len_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      first_q     <= '0;
      rest_q      <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= '0;
        first_q <= '0;
        rest_q  <= '0;
      end else if (advance) begin
        count_q <= is_last ? '0 : count_next;
        first_q <= is_last ? '0 : first_new;
        rest_q  <= is_last ? '0 : rest_new;
      end

      if (byte_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end

      if (advance && is_last) begin
        out_valid_q <= 1'b1;
      end else if (sum_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_accept) begin
      byte_q <= byte_i.rom_byte;
    end
    if (advance && is_last) begin
      checksum_q   <= sum_d;
      complement_q <= sum_d ^ ComplementMask;
    end
  end

  // No byte may enter while the derived lengths are being recomputed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      cfg_we_i |=> !byte_i.ready)
    else $error("byte accepted while configuration settles");

  // The byte count never reaches a nonzero image size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (rom_size_q != '0) |-> (count_q < rom_size_q))
    else $error("byte count ran past the image size");

  // A last byte facing a stalled full output register stays in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (in_valid_q && is_last && out_valid_q && !sum_o.ready) |=> in_valid_q)
    else $error("last byte dropped while the result was stalled");

endmodule
